// ===== hdl/utf8_stream_transcoder_macros.svh =====
// Assertion macros for the UTF-8 stream transcoder.
`ifndef UTF8_STREAM_TRANSCODER_MACROS_SVH
`define UTF8_STREAM_TRANSCODER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising clk_i edge outside reset.
`define UT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising clk_i edge, reset included.
`define UT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define UT_ASSERT(lbl, prop, msg)
`define UT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/utf8st_pkg.sv =====
// Shared types and constants for the UTF-8 stream transcoder.
`default_nettype none
package utf8st_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [1:0] MODE_UTF32 = 2'd0;
  localparam logic [1:0] MODE_UTF16 = 2'd1;
  localparam logic [1:0] MODE_ASCII = 2'd2;

  localparam logic CFG_IDX_OUTPUT_MODE = 1'b0;
  localparam logic CFG_IDX_REPLACEMENT = 1'b1;

  localparam int unsigned CFG_DATA_W = 7;
  localparam logic [1:0] MODE_RESET = MODE_UTF32;
  localparam logic [6:0] REPL_RESET = 7'd63;

  localparam logic [CP_W-1:0] UTF16_MAX = 21'h10FFFF;
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;
  localparam logic [5:0] HI_SURR_TAG = 6'b110110;
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CP_W-1:0] code_unit;
    logic            is_error;
    logic            run_last;
    logic            string_end;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } dec_out_t;

endpackage
`default_nettype wire

// ===== hdl/utf8st_in_if.sv =====
// Input channel: one UTF-8 byte per transaction.
`default_nettype none
interface utf8st_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_last;

  modport source (output valid, output in_byte, output string_last, input ready);
  modport sink   (input valid, input in_byte, input string_last, output ready);
endinterface
`default_nettype wire

// ===== hdl/utf8st_out_if.sv =====
// Output channel: one code unit per transaction.
`default_nettype none
interface utf8st_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_unit;
  logic        is_error;
  logic        run_last;
  logic        string_end;

  modport source (output valid, output code_unit, output is_error, output run_last,
                  output string_end, input ready);
  modport sink   (input valid, input code_unit, input is_error, input run_last,
                  input string_end, output ready);
endinterface
`default_nettype wire

// ===== hdl/utf8st_decode.sv =====
// UTF-8 sequence decoder with output-form conversion; holds decode state.
`default_nettype none
module utf8st_decode (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [7:0]              byte_i,
  input  logic                    last_i,
  input  logic [1:0]              mode_i,
  input  logic [6:0]              repl_i,
  output utf8st_pkg::dec_out_t    dec_o
);

  logic [utf8st_pkg::CP_W-1:0] part_q, part_d;
  logic [1:0]                  pend_q, pend_d;
  logic                        disc_q, disc_d;

  logic [utf8st_pkg::CP_W-1:0] shifted;
  logic [utf8st_pkg::CP_W-1:0] emit_cp;
  logic [utf8st_pkg::CP_W-1:0] supp_off;
  logic                        emit_en;
  logic                        fail_en;

  assign shifted  = {part_q[utf8st_pkg::CP_W-7:0], byte_i[5:0]};
  assign supp_off = emit_cp - utf8st_pkg::SUPP_BASE;

  always_comb begin
    dec_o   = '0;
    part_d  = part_q;
    pend_d  = pend_q;
    disc_d  = disc_q;
    emit_en = 1'b0;
    emit_cp = '0;
    fail_en = 1'b0;

    if (disc_q) begin
      if (last_i) disc_d = 1'b0;
    end else if (pend_q != 2'd0) begin
      part_d = shifted;
      pend_d = pend_q - 2'd1;
      if (pend_q == 2'd1) begin
        part_d  = '0;
        emit_en = 1'b1;
        emit_cp = shifted;
      end else begin
        fail_en = last_i;
      end
    end else begin
      priority if (!byte_i[7]) begin
        emit_en = 1'b1;
        emit_cp = {13'd0, byte_i};
      end else if (byte_i[7:5] == 3'b110) begin
        part_d  = {16'd0, byte_i[4:0]};
        pend_d  = 2'd1;
        fail_en = last_i;
      end else if (byte_i[7:4] == 4'b1110) begin
        part_d  = {17'd0, byte_i[3:0]};
        pend_d  = 2'd2;
        fail_en = last_i;
      end else if (byte_i[7:3] == 5'b11110) begin
        part_d  = {18'd0, byte_i[2:0]};
        pend_d  = 2'd3;
        fail_en = last_i;
      end else begin
        fail_en = 1'b1;
      end
    end

    if (emit_en) begin
      dec_o.count           = 2'd1;
      dec_o.res0.code_unit  = emit_cp;
      dec_o.res0.run_last   = 1'b1;
      dec_o.res0.string_end = last_i;
      unique case (mode_i)
        utf8st_pkg::MODE_UTF16: begin
          if (emit_cp > utf8st_pkg::UTF16_MAX) begin
            fail_en = 1'b1;
          end else if (emit_cp >= utf8st_pkg::SUPP_BASE) begin
            dec_o.count           = 2'd2;
            dec_o.res0.code_unit  = {5'd0, utf8st_pkg::HI_SURR_TAG, supp_off[19:10]};
            dec_o.res0.run_last   = 1'b0;
            dec_o.res0.string_end = 1'b0;
            dec_o.res1.code_unit  = {5'd0, utf8st_pkg::LO_SURR_TAG, supp_off[9:0]};
            dec_o.res1.is_error   = 1'b0;
            dec_o.res1.run_last   = 1'b1;
            dec_o.res1.string_end = last_i;
          end
        end
        utf8st_pkg::MODE_ASCII: begin
          if (emit_cp[utf8st_pkg::CP_W-1:7] != '0) begin
            dec_o.res0.code_unit = {14'd0, repl_i};
          end
        end
        default: ;
      endcase
    end

    if (fail_en) begin
      part_d                = '0;
      pend_d                = 2'd0;
      disc_d                = !last_i;
      dec_o                 = '0;
      dec_o.count           = 2'd1;
      dec_o.res0.is_error   = 1'b1;
      dec_o.res0.run_last   = 1'b1;
      dec_o.res0.string_end = last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
      pend_q <= 2'd0;
      disc_q <= 1'b0;
    end else if (step_i) begin
      part_q <= part_d;
      pend_q <= pend_d;
      disc_q <= disc_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/utf8st_outq.sv =====
// Result queue: takes up to two results per cycle, delivers one per transaction.
`default_nettype none
module utf8st_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  utf8st_pkg::dec_out_t wr_i,
  output logic                 room_o,
  utf8st_out_if.source         out_o
);

  utf8st_pkg::res_t                  entry_q [utf8st_pkg::QDEPTH];
  logic [utf8st_pkg::QPTR_W-1:0]     wp_q, rp_q;
  logic [utf8st_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  logic                              pop;
  utf8st_pkg::res_t                  head;

  assign head             = entry_q[rp_q];
  assign out_o.valid      = cnt_q != '0;
  assign out_o.code_unit  = head.code_unit;
  assign out_o.is_error   = head.is_error;
  assign out_o.run_last   = head.run_last;
  assign out_o.string_end = head.string_end;

  assign pop    = out_o.valid && out_o.ready;
  assign room_o = cnt_q <= utf8st_pkg::QCNT_W'(utf8st_pkg::QDEPTH - 2);
  assign cnt_d  = cnt_q + utf8st_pkg::QCNT_W'(wr_i.count) - utf8st_pkg::QCNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (wr_i.count != 2'd0) entry_q[wp_q] <= wr_i.res0;
    if (wr_i.count == 2'd2) entry_q[wp_q + utf8st_pkg::QPTR_W'(1)] <= wr_i.res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + utf8st_pkg::QPTR_W'(wr_i.count);
      rp_q  <= rp_q + utf8st_pkg::QPTR_W'(pop);
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/utf8_stream_transcoder.sv =====
// UTF-8 stream transcoder top level: input register, decoder, result queue.
// Data path: a byte is held in the input register, decoded, then written to the result queue.
// Throughput: one byte per cycle while the queue has room; a surrogate pair holds the output for two transactions.
// The four-entry result queue takes a byte only with room for two results.
// Reset (async, active low) clears decode state and queue; output_mode 0, replacement 63.
`default_nettype none
`include "utf8_stream_transcoder_macros.svh"
module utf8_stream_transcoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [utf8st_pkg::CFG_DATA_W-1:0] cfg_data_i,
  utf8st_in_if.sink   in_i,
  utf8st_out_if.source out_o
);

  logic [1:0] mode_q;
  logic [6:0] repl_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       advance;
  logic       room;

  utf8st_pkg::dec_out_t dec, dec_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= utf8st_pkg::MODE_RESET;
      repl_q <= utf8st_pkg::REPL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        utf8st_pkg::CFG_IDX_OUTPUT_MODE: mode_q <= cfg_data_i[1:0];
        utf8st_pkg::CFG_IDX_REPLACEMENT: repl_q <= cfg_data_i;
      endcase
    end
  end

  assign advance  = in_valid_q && room;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.in_byte;
      in_last_q <= in_i.string_last;
    end
  end

  utf8st_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .mode_i (mode_q),
    .repl_i (repl_q),
    .dec_o  (dec)
  );

  always_comb begin
    dec_wr = dec;
    if (!advance) dec_wr.count = 2'd0;
  end

  utf8st_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (dec_wr),
    .room_o (room),
    .out_o  (out_o)
  );

  `UT_ASSERT(a_err_zero,
             out_o.valid && out_o.is_error |-> out_o.code_unit == 21'd0,
             "error result with nonzero code unit")
  `UT_ASSERT(a_end_last,
             out_o.valid && out_o.string_end |-> out_o.run_last,
             "string end without run last")
  `UT_ASSERT(a_pair_utf16,
             advance && dec.count == 2'd2 |->
               mode_q == utf8st_pkg::MODE_UTF16 && !dec.res0.run_last,
             "pair outside UTF-16 mode")
  `UT_ASSERT_ALWAYS(a_empty_ready,
                    !in_valid_q |-> in_i.ready,
                    "input stalled with empty register")

endmodule
`default_nettype wire
